### design/bgtr_pkg.sv
// Shared constants, field layout and controller/datapath interface types for the glyph renderer.
package bgtr_pkg;

	localparam int GLYPH_HEIGHT = 8;
	localparam int GLYPH_COUNT  = 256;
	localparam int COORD_BITS   = 12;

	localparam int FONT_DEPTH = 2048;
	localparam int FONT_AW    = 11;
	localparam int ROW_W      = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;
	localparam int PIX_W      = 24;
	localparam int FBW_W      = 13;
	localparam logic [FBW_W-1:0] FBW_RESET = FBW_W'(640);
	localparam logic [7:0] MSB_MASK = 8'b10000000;

	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 48;

	// Input tdata bit offsets
	localparam int OFF_FONT_INDEX = 0;
	localparam int OFF_FONT_BYTE  = 11;
	localparam int OFF_CHAR_CODE  = 19;
	localparam int OFF_NEW_STRING = 27;
	localparam int OFF_START_X    = 28;
	localparam int OFF_START_Y    = 40;
	localparam int OFF_RED        = 52;
	localparam int OFF_GREEN      = 60;
	localparam int OFF_BLUE       = 68;

	localparam logic KIND_FONT_WR = 1'b0;
	localparam logic KIND_DRAW    = 1'b1;

	typedef struct packed {
		logic             start;
		logic             font_wr;
		logic             rd_en;
		logic             scan;
		logic             load_row;
		logic             advance;
		logic [ROW_W-1:0] row;
		logic [2:0]       col;
	} ctrl_cmd_t;

	typedef struct packed {
		logic pix_set;
		logic slot_free;
	} dp_stat_t;

endpackage

### design/bitmap_glyph_text_renderer.sv
// Top level of the bitmap glyph text renderer: controller plus datapath.
// Font write: the byte is written as it is taken, and the next item is taken in the following cycle.
// Draw: a scan pass reads the glyph rows to find the last non-empty row, then each row is
// fetched (read, then load) and walked one column per cycle, except while a set pixel waits
// for the output register. The single glyph-store read port and the column walk set the pace.
// Reset: cursor to 0,0, fb_width to 640, output empty; the glyph store is not cleared.
module bitmap_glyph_text_renderer (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Register write port for fb_width
	input  logic                                 cfg_we,
	input  logic [bgtr_pkg::FBW_W-1:0]           cfg_wdata,
	// Input stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// tdata from bit 0: font_index[11], font_byte[8], char_code[8], new_string[1],
	// start_x[12], start_y[12], red[8], green[8], blue[8], zero pad[4]
	input  logic [bgtr_pkg::IN_TDATA_W-1:0]      s_tdata,
	// tuser: kind (0 font byte write, 1 draw character)
	input  logic                                 s_tuser,
	// Output stream of pixel writes
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// tdata from bit 0: pixel_index[24], pixel_color[24]
	output logic [bgtr_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// tlast: final pixel transfer for this character
	output logic                                 m_tlast
);

	bgtr_pkg::ctrl_cmd_t cmd;
	bgtr_pkg::dp_stat_t  stat;

	// Sequence one item at a time; a character never overlaps the next input transfer
	bgtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold the font, cursor and pixel arithmetic; the output register lets the
	// last pixel of one character wait while the next item is taken
	bgtr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.cmd       (cmd),
		.stat      (stat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

endmodule

### design/bgtr_ctrl.sv
// Sequencer for the glyph renderer: scan pass, row fetch and pixel walk.
module bgtr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tuser,
	output logic                s_tready,
	input  bgtr_pkg::dp_stat_t  stat,
	output bgtr_pkg::ctrl_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_SCAN     = 6'b000010,
		ST_SCAN_END = 6'b000100,
		ST_RD       = 6'b001000,
		ST_LD       = 6'b010000,
		ST_PIX      = 6'b100000
	} state_t;

	localparam logic [bgtr_pkg::ROW_W-1:0] LAST_ROW =
		bgtr_pkg::ROW_W'(bgtr_pkg::GLYPH_HEIGHT - 1);

	state_t                      state_q, state_d;
	logic [bgtr_pkg::ROW_W-1:0]  row_q, row_d;
	logic [2:0]                  col_q, col_d;

	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		col_d       = col_q;
		cmd         = '0;
		cmd.row     = row_q;
		cmd.col     = col_q;
		s_tready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (s_tuser == bgtr_pkg::KIND_DRAW) begin
						cmd.start = 1'b1;
						row_d     = '0;
						state_d   = ST_SCAN;
					end else begin
						cmd.font_wr = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				cmd.rd_en = 1'b1;
				cmd.scan  = 1'b1;
				if (row_q == LAST_ROW) begin
					row_d   = '0;
					state_d = ST_SCAN_END;
				end else begin
					row_d = row_q + 1'b1;
				end
			end
			ST_SCAN_END: state_d = ST_RD;
			ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = ST_LD;
			end
			ST_LD: begin
				cmd.load_row = 1'b1;
				col_d        = '0;
				state_d      = ST_PIX;
			end
			ST_PIX: begin
				if (!stat.pix_set || stat.slot_free) begin
					cmd.advance = 1'b1;
					col_d       = col_q + 1'b1;
					if (col_q == 3'd7) begin
						if (row_q == LAST_ROW) begin
							state_d = ST_IDLE;
						end else begin
							row_d   = row_q + 1'b1;
							state_d = ST_RD;
						end
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			state_q <= state_d;
			row_q   <= row_d;
			col_q   <= col_d;
		end
	end

endmodule

### design/bgtr_dp.sv
// Datapath of the glyph renderer: glyph store, cursor, address arithmetic and output register.
module bgtr_dp (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bgtr_pkg::FBW_W-1:0]           cfg_wdata,
	input  logic [bgtr_pkg::IN_TDATA_W-1:0]      s_tdata,
	input  bgtr_pkg::ctrl_cmd_t                  cmd,
	output bgtr_pkg::dp_stat_t                   stat,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [bgtr_pkg::OUT_TDATA_W-1:0]     m_tdata,
	output logic                                 m_tlast
);

	localparam int CB = bgtr_pkg::COORD_BITS;
	localparam int PW = bgtr_pkg::PIX_W;

	logic [7:0] font_mem [bgtr_pkg::FONT_DEPTH];

	logic [bgtr_pkg::FBW_W-1:0]    fb_width_q;
	logic [CB-1:0]                 cursor_x_q, cursor_y_q;
	logic [CB-1:0]                 x_q, y_q;
	logic [7:0]                    code_q;
	logic [23:0]                   color_q;
	logic [7:0]                    rdata_q;
	logic                          scan_s1;
	logic [bgtr_pkg::ROW_W-1:0]    row_s1;
	logic [bgtr_pkg::ROW_W-1:0]    last_row_q;
	logic [7:0]                    bits_q;
	logic [PW-1:0]                 row_base_q;
	logic                          m_tvalid_q, m_tlast_q;
	logic [PW-1:0]                 pix_index_q;
	logic [23:0]                   pix_color_q;

	logic [10:0]                   in_font_index;
	logic [7:0]                    in_font_byte, in_code, code_red;
	logic                          in_new;
	logic [CB-1:0]                 in_x, in_y, start_x, start_y;
	logic [bgtr_pkg::FONT_AW-1:0]  rd_addr;
	logic [PW-1:0]                 y_row, pix_addr;
	logic                          pix_last;

	assign in_font_index = s_tdata[bgtr_pkg::OFF_FONT_INDEX +: 11];
	assign in_font_byte  = s_tdata[bgtr_pkg::OFF_FONT_BYTE +: 8];
	assign in_code       = s_tdata[bgtr_pkg::OFF_CHAR_CODE +: 8];
	assign in_new        = s_tdata[bgtr_pkg::OFF_NEW_STRING];
	assign in_x          = s_tdata[bgtr_pkg::OFF_START_X +: CB];
	assign in_y          = s_tdata[bgtr_pkg::OFF_START_Y +: CB];

	// Code below twice the glyph count: one compare and subtract wraps it
	assign code_red = (9'(in_code) >= 9'(bgtr_pkg::GLYPH_COUNT)) ?
		8'(9'(in_code) - 9'(bgtr_pkg::GLYPH_COUNT)) : in_code;

	assign start_x = in_new ? in_x : cursor_x_q;
	assign start_y = in_new ? in_y : cursor_y_q;

	assign rd_addr = bgtr_pkg::FONT_AW'(32'(code_q) * bgtr_pkg::GLYPH_HEIGHT + 32'(cmd.row));

	assign y_row    = PW'(y_q) + PW'(cmd.row);
	assign pix_addr = row_base_q + PW'(x_q) + PW'(cmd.col);
	assign pix_last = (cmd.row == last_row_q) && (bits_q[6:0] == 7'd0);

	assign stat.pix_set   = (bits_q & bgtr_pkg::MSB_MASK) != 8'd0;
	assign stat.slot_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.font_wr) begin
			font_mem[in_font_index] <= in_font_byte;
		end
		if (cmd.rd_en) begin
			rdata_q <= font_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fb_width_q <= bgtr_pkg::FBW_RESET;
			cursor_x_q <= '0;
			cursor_y_q <= '0;
			scan_s1    <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				fb_width_q <= cfg_wdata;
			end
			if (cmd.start) begin
				cursor_x_q <= start_x + CB'(8);
				cursor_y_q <= start_y;
			end
			scan_s1 <= cmd.scan;
			if (cmd.advance && stat.pix_set) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q        <= start_x;
			y_q        <= start_y;
			code_q     <= code_red;
			color_q    <= {s_tdata[bgtr_pkg::OFF_RED +: 8], s_tdata[bgtr_pkg::OFF_GREEN +: 8],
				s_tdata[bgtr_pkg::OFF_BLUE +: 8]};
			last_row_q <= '0;
		end
		row_s1 <= cmd.row;
		// Track the last glyph row that has any pixel set
		if (scan_s1 && rdata_q != 8'd0) begin
			last_row_q <= row_s1;
		end
		if (cmd.load_row) begin
			bits_q     <= rdata_q;
			row_base_q <= PW'(fb_width_q) * y_row;
		end else if (cmd.advance) begin
			bits_q <= {bits_q[6:0], 1'b0};
		end
		if (cmd.advance && stat.pix_set) begin
			pix_index_q <= pix_addr;
			pix_color_q <= color_q;
			m_tlast_q   <= pix_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {pix_color_q, pix_index_q};
	assign m_tlast  = m_tlast_q;

endmodule
